// ===== hw/rtl/kdp_pkg.sv =====
// Shared widths, the capacity reset value and the update result type for the knapsack block.
`default_nettype none
package kdp_pkg;
    localparam int CAP_W           = 12;
    localparam int WEIGHT_W        = 16;
    localparam int VALUE_W         = 16;
    localparam int BEST_W          = 32;
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam logic [CAP_W-1:0] CAP_RESET = 12'hFFF;

    typedef struct packed {
        logic              we;
        logic [BEST_W-1:0] data;
    } t_upd;
endpackage
`default_nettype wire

// ===== hw/rtl/kdp_table.sv =====
// Best-value table: one write port, two registered read ports.
`default_nettype none
module kdp_table
    import kdp_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [BEST_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr_a,
    input  wire logic [AW-1:0]     i_raddr_b,
    output logic      [BEST_W-1:0] o_rdata_a,
    output logic      [BEST_W-1:0] o_rdata_b
);
    logic [BEST_W-1:0] r_mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/kdp_alu.sv =====
// Shared update unit: saturating add of the item value and compare with the current entry.
`default_nettype none
module kdp_alu
    import kdp_pkg::*;
(
    input  wire logic               i_en,
    input  wire logic [BEST_W-1:0]  i_cur,
    input  wire logic [BEST_W-1:0]  i_lower,
    input  wire logic [VALUE_W-1:0] i_value,
    output t_upd                    o_upd
);
    logic [BEST_W:0]   sum;
    logic [BEST_W-1:0] cand;

    always_comb begin
        sum        = {1'b0, i_lower} + (BEST_W+1)'(i_value);
        cand       = sum[BEST_W] ? '1 : sum[BEST_W-1:0];
        o_upd.data = cand;
        o_upd.we   = i_en && (cand > i_cur);
    end
endmodule
`default_nettype wire

// ===== hw/rtl/knapsack_01_dp_top.sv =====
// Top level of the 0/1 knapsack solver: sequencer around the table and update unit.
//
// Usage: write the capacity on the cfg channel (i_cfg_valid/o_cfg_ready, ready always
// high) while the block is idle. Present an item with start while busy is low; the
// item is taken at that edge and busy rises for its walk.
// An item of weight w at effective capacity C (capacity limited to TABLE_DEPTH-1)
// walks entries C down to w, one entry per cycle through the shared update unit and
// a one-deep read/write pipeline on the table; busy stays high through the walk and
// a drain state. An item heavier than C has no walk; busy stays low unless it is last.
// For a last item, states S_RDCAP and S_RDOUT then read the entry at C;
// o_best_value_valid pulses for one cycle, and the table is cleared at one entry per
// cycle, all TABLE_DEPTH entries, before busy drops again.
// Reset: capacity returns to 4095 and a clearing pass over all TABLE_DEPTH entries
// runs with busy high; configuration writes are still taken.
// The result is shown for exactly one cycle; the receiver cannot stall it.
`default_nettype none
module knapsack_01_dp_top
    import kdp_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [WEIGHT_W-1:0] i_item_weight,
    input  wire logic [VALUE_W-1:0]  i_item_value,
    input  wire logic                i_last_item,
    output logic [BEST_W-1:0]        o_best_value,
    output logic                     o_best_value_valid,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CAP_W-1:0]    i_cfg_data
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] TOP_ADDR = AW'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_WALK, S_DRAIN, S_RDCAP, S_RDOUT
    } t_state;

    t_state              r_state, n_state;
    logic [CAP_W-1:0]    r_cap_limit;
    logic [AW-1:0]       r_addr, n_addr;
    logic [AW-1:0]       r_cap, n_cap;
    logic [AW-1:0]       r_wt, n_wt;
    logic [VALUE_W-1:0]  r_val, n_val;
    logic                r_last, n_last;
    logic                r_p1, n_p1;
    logic [AW-1:0]       r_p1_addr, n_p1_addr;
    logic [BEST_W-1:0]   r_out, n_out;
    logic                r_out_vld, n_out_vld;

    logic [AW-1:0]       eff_cap;
    logic                tbl_we;
    logic [AW-1:0]       tbl_waddr, tbl_raddr_a, tbl_raddr_b;
    logic [BEST_W-1:0]   tbl_wdata, rdata_a, rdata_b;
    t_upd                upd;

    assign o_cfg_ready        = 1'b1;
    assign busy               = (r_state != S_IDLE);
    assign o_best_value       = r_out;
    assign o_best_value_valid = r_out_vld;

    assign eff_cap = (32'(r_cap_limit) > 32'(TABLE_DEPTH - 1)) ? TOP_ADDR : AW'(r_cap_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_limit <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap_limit <= i_cfg_data;
        end
    end

    kdp_alu u_alu (
        .i_en    (r_p1),
        .i_cur   (rdata_a),
        .i_lower (rdata_b),
        .i_value (r_val),
        .o_upd   (upd)
    );

    always_comb begin
        tbl_raddr_a = (r_state == S_RDCAP) ? r_cap : r_addr;
        tbl_raddr_b = r_addr - r_wt;
        if (r_state == S_CLEAR) begin
            tbl_we    = 1'b1;
            tbl_waddr = r_addr;
            tbl_wdata = '0;
        end else begin
            tbl_we    = upd.we;
            tbl_waddr = r_p1_addr;
            tbl_wdata = upd.data;
        end
    end

    kdp_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
        .i_clk     (i_clk),
        .i_we      (tbl_we),
        .i_waddr   (tbl_waddr),
        .i_wdata   (tbl_wdata),
        .i_raddr_a (tbl_raddr_a),
        .i_raddr_b (tbl_raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_cap     = r_cap;
        n_wt      = r_wt;
        n_val     = r_val;
        n_last    = r_last;
        n_p1      = 1'b0;
        n_p1_addr = r_addr;
        n_out     = r_out;
        n_out_vld = 1'b0;
        case (r_state)
            S_CLEAR: begin
                if (r_addr == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr - AW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_wt   = AW'(32'(i_item_weight));
                    n_val  = i_item_value;
                    n_last = i_last_item;
                    n_cap  = eff_cap;
                    n_addr = eff_cap;
                    if (32'(i_item_weight) <= 32'(eff_cap)) begin
                        n_state = S_WALK;
                    end else if (i_last_item) begin
                        n_state = S_RDCAP;
                    end
                end
            end
            S_WALK: begin
                n_p1 = 1'b1;
                if (r_addr == r_wt) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr - AW'(1);
                end
            end
            S_DRAIN: begin
                n_state = r_last ? S_RDCAP : S_IDLE;
            end
            S_RDCAP: begin
                n_state = S_RDOUT;
            end
            S_RDOUT: begin
                n_out     = rdata_a;
                n_out_vld = 1'b1;
                n_addr    = TOP_ADDR;
                n_state   = S_CLEAR;
            end
            default: begin
                n_state = S_CLEAR;
                n_addr  = TOP_ADDR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= TOP_ADDR;
            r_p1      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_p1      <= n_p1;
            r_out_vld <= n_out_vld;
        end
        r_cap     <= n_cap;
        r_wt      <= n_wt;
        r_val     <= n_val;
        r_last    <= n_last;
        r_p1_addr <= n_p1_addr;
        r_out     <= n_out;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/kdp_chk.sv =====
// Port-level checks for the knapsack block, bound to the top level.
`default_nettype none
module kdp_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_best_value_valid
);
    // a result beat falls in the clearing pass, with busy high
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_best_value_valid |-> busy)
        else $error("result beat while idle");

    a_out_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_best_value_valid |=> !o_best_value_valid)
        else $error("result beat repeated");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not clearing after reset");

    a_no_result_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_best_value_valid)
        else $error("result beat right after an item was taken");
endmodule

bind knapsack_01_dp_top kdp_chk u_kdp_chk (.*);
`default_nettype wire
